### rtl/gtt_pkg.sv
// Package for the GCRA traffic throttle.
// Shared item kinds and configuration register indexes; no dependencies.
package gtt_pkg;

  // Item kind, carried in the input tuser field
  typedef enum logic [1:0] {
    MODE_REQUEST = 2'd0,
    MODE_COMMIT  = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_IDLE    = 2'd3   // unused code: no state change
  } mode_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_INCREMENT = 1'b0,
    CFG_BURST     = 1'b1
  } cfg_idx_e;

  localparam int unsigned FillBits  = 48;
  localparam int unsigned IncBits   = 32;
  localparam int unsigned CountBits = 16;
  localparam int unsigned StampBits = 48;

endpackage

### rtl/gtt_front.sv
// Front end of the GCRA throttle: decodes the item kind, forms the commit
// charge (events * increment) and the restart commit time. Uses gtt_pkg.
module gtt_front #(
  parameter int unsigned TimeBits = 48,
  parameter int unsigned OpndBits = 48
) (
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,   // [47:0] timestamp, [63:48] event_count
  input  logic [1:0]            s_axis_tuser,   // [1:0] mode
  input  logic [31:0]           increment_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output gtt_pkg::mode_e        q_kind_o,
  output logic [TimeBits-1:0]   q_stamp_o,
  output logic [OpndBits-1:0]   q_opnd_o
);
  import gtt_pkg::*;

  logic [StampBits-1:0] stamp_in;
  logic [CountBits-1:0] count_in;
  logic [TimeBits-1:0]  stamp;
  logic [TimeBits-1:0]  inc_t;
  logic [FillBits-1:0]  charge;
  mode_e                kind;

  assign stamp_in = s_axis_tdata[StampBits-1:0];
  assign count_in = s_axis_tdata[StampBits+CountBits-1:StampBits];
  assign kind     = mode_e'(s_axis_tuser);

  // timestamps live modulo 2^TimeBits
  assign stamp  = TimeBits'(stamp_in);
  assign inc_t  = TimeBits'(increment_i);
  assign charge = FillBits'(count_in) * FillBits'(increment_i);

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;
  assign q_kind_o      = kind;
  assign q_stamp_o     = stamp;

  always_comb begin
    unique case (kind)
      MODE_COMMIT:  q_opnd_o = OpndBits'(charge);
      MODE_RESTART: q_opnd_o = OpndBits'(stamp - inc_t);
      default:      q_opnd_o = '0;
    endcase
  end

endmodule

### rtl/gtt_fifo.sv
// Two-entry queue between front and back of the GCRA throttle.
// Generic width; no package dependency beyond its own logic.
module gtt_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign valid_o    = count_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/gtt_back.sv
// Back end of the GCRA throttle: flow state, flag histories, alarm and
// the output register. Uses gtt_pkg.
module gtt_back #(
  parameter int unsigned TimeBits = 48,
  parameter int unsigned OpndBits = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [47:0]         burst_limit_i,
  input  logic                q_valid_i,
  input  gtt_pkg::mode_e      q_kind_i,
  input  logic [TimeBits-1:0] q_stamp_i,
  input  logic [OpndBits-1:0] q_opnd_i,
  output logic                q_pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,  // [47:0] delay_ticks
  output logic [2:0]          m_axis_tuser   // [0] alarm, [1] is_full, [2] is_empty
);
  import gtt_pkg::*;

  localparam int unsigned CmpBits = (TimeBits > FillBits) ? TimeBits : FillBits;

  logic [TimeBits-1:0] commit_time_q, commit_time_d;
  logic [TimeBits-1:0] request_time_q, request_time_d;
  logic [FillBits-1:0] exp_fill_q, exp_fill_d;
  logic [FillBits-1:0] act_fill_q, act_fill_d;
  logic [2:0]          full_hist_q, full_hist_d;
  logic [2:0]          empty_hist_q, empty_hist_d;
  logic [1:0]          alarm_hist_q, alarm_hist_d;
  logic                out_valid_q, out_valid_d;
  logic [FillBits-1:0] delay_q, delay_d;
  logic [2:0]          flags_q, flags_d;

  logic                exec;
  logic [TimeBits-1:0] elapsed;
  logic [CmpBits:0]    exp_x, elapsed_x, remain_x;
  logic [FillBits-1:0] remain;
  logic [FillBits:0]   sum;

  assign exec    = q_valid_i && (!out_valid_q || m_axis_tready);
  assign q_pop_o = exec;

  assign elapsed   = q_stamp_i - commit_time_q;
  assign exp_x     = (CmpBits+1)'(exp_fill_q);
  assign elapsed_x = (CmpBits+1)'(elapsed);
  assign remain_x  = exp_x - elapsed_x;
  assign remain    = remain_x[FillBits-1:0];
  assign sum       = {1'b0, act_fill_q} + {1'b0, q_opnd_i[FillBits-1:0]};

  always_comb begin
    commit_time_d  = commit_time_q;
    request_time_d = request_time_q;
    exp_fill_d     = exp_fill_q;
    act_fill_d     = act_fill_q;
    full_hist_d    = full_hist_q;
    empty_hist_d   = empty_hist_q;
    alarm_hist_d   = alarm_hist_q;
    delay_d        = '0;

    if (exec) begin
      unique case (q_kind_i)
        MODE_REQUEST: begin
          request_time_d  = q_stamp_i;
          full_hist_d[0]  = 1'b0;
          empty_hist_d[0] = 1'b0;
          if (exp_x <= elapsed_x) begin
            act_fill_d      = '0;
            empty_hist_d[0] = 1'b1;
          end else begin
            act_fill_d = remain;
            if (remain > burst_limit_i) begin
              full_hist_d[0] = 1'b1;
              delay_d        = remain - burst_limit_i;
            end
          end
        end
        MODE_COMMIT: begin
          commit_time_d = request_time_q;
          exp_fill_d    = sum[FillBits] ? '1 : sum[FillBits-1:0];
          full_hist_d   = {full_hist_q[1:0], full_hist_q[0]};
          empty_hist_d  = {empty_hist_q[1:0], empty_hist_q[0]};
          alarm_hist_d  = {alarm_hist_q[0], alarm_hist_q[0]};
          // hysteresis: clear on entering empty, set on entering full
          if (empty_hist_q[0] && !empty_hist_q[1]) begin
            alarm_hist_d[0] = 1'b0;
          end else if (full_hist_q[0] && !full_hist_q[1]) begin
            alarm_hist_d[0] = 1'b1;
          end
        end
        MODE_RESTART: begin
          request_time_d = q_stamp_i;
          commit_time_d  = q_opnd_i[TimeBits-1:0];
          exp_fill_d     = '0;
          act_fill_d     = '0;
          full_hist_d    = 3'b000;
          empty_hist_d   = 3'b111;
          alarm_hist_d   = 2'b00;
        end
        default: ;
      endcase
    end

    flags_d = {empty_hist_d[0], full_hist_d[0], alarm_hist_d[0]};

    if (exec) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      commit_time_q  <= '0;
      request_time_q <= '0;
      exp_fill_q     <= '0;
      act_fill_q     <= '0;
      full_hist_q    <= 3'b000;
      empty_hist_q   <= 3'b111;
      alarm_hist_q   <= 2'b00;
      out_valid_q    <= 1'b0;
    end else begin
      commit_time_q  <= commit_time_d;
      request_time_q <= request_time_d;
      exp_fill_q     <= exp_fill_d;
      act_fill_q     <= act_fill_d;
      full_hist_q    <= full_hist_d;
      empty_hist_q   <= empty_hist_d;
      alarm_hist_q   <= alarm_hist_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      delay_q <= delay_d;
      flags_q <= flags_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = delay_q;
  assign m_axis_tuser  = flags_q;

  // a bucket cannot be found full and drained by the same request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_hist_q[0] && empty_hist_q[0]))
    else $error("full and empty flags both set");

  // a non-zero delay only comes with the full flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (delay_q != '0)) |-> flags_q[1])
    else $error("delay reported without full flag");

  // a restart leaves a drained, quiet bucket
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && (q_kind_i == MODE_RESTART)) |=>
      (out_valid_q && (flags_q == 3'b100) && (exp_fill_q == '0)))
    else $error("restart did not clear flow state");

endmodule

### rtl/gcra_traffic_throttle_top.sv
// Top level of the GCRA traffic throttle: configuration registers and the
// front, queue and back instances. Uses gtt_pkg, gtt_front, gtt_fifo, gtt_back.
//
// Usage:
//   Input stream (s_axis_*): one item per transfer. tuser carries the mode
//   (request, commit, restart); tdata carries timestamp and event count.
//   Output stream (m_axis_*): exactly one result per input item, in order:
//   delay in tdata, alarm / full / empty flags in tuser.
//   Config channel (cfg_*): index 0 writes increment_ticks (low 32 bits of
//   cfg_data_i), index 1 writes burst_limit. Always ready; write only while
//   no item is in flight.
//   Throughput is one item per cycle while the receiver accepts results.
//   From input acceptance to output valid an item passes the two-entry queue,
//   then the back end's output register. The back end's flow-state update
//   (subtract, compare, saturating add) is combinational into its state
//   registers. The commit charge multiply is done in the front before the queue.
//   Reset clears the queue, the output valid bit and the flow state
//   (empty history all ones), and sets increment_ticks 1, burst_limit 0.
//   When the receiver stalls the output register holds its result, the
//   queue fills, and s_axis_tready drops once both queue entries are taken.
module gcra_traffic_throttle_top #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [47:0] timestamp, [63:48] event_count
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [47:0] delay_ticks
  output logic [2:0]  m_axis_tuser,   // [0] alarm, [1] is_full, [2] is_empty
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_data_i
);
  import gtt_pkg::*;

  localparam int unsigned OpndBits  = (TIME_BITS > FillBits) ? TIME_BITS : FillBits;
  localparam int unsigned EntryBits = 2 + TIME_BITS + OpndBits;

  logic [IncBits-1:0]  increment_q, increment_d;
  logic [FillBits-1:0] burst_q, burst_d;

  logic                 q_push, q_full, q_pop, q_valid;
  mode_e                f_kind, b_kind;
  logic [TIME_BITS-1:0] f_stamp, b_stamp;
  logic [OpndBits-1:0]  f_opnd, b_opnd;
  logic [EntryBits-1:0] push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    increment_d = increment_q;
    burst_d     = burst_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_INCREMENT: increment_d = cfg_data_i[IncBits-1:0];
        CFG_BURST:     burst_d     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      increment_q <= IncBits'(1);
      burst_q     <= '0;
    end else begin
      increment_q <= increment_d;
      burst_q     <= burst_d;
    end
  end

  gtt_front #(
    .TimeBits (TIME_BITS),
    .OpndBits (OpndBits)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .increment_i   (increment_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_kind_o      (f_kind),
    .q_stamp_o     (f_stamp),
    .q_opnd_o      (f_opnd)
  );

  assign push_data = {f_kind, f_stamp, f_opnd};

  gtt_fifo #(
    .Width (EntryBits)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  assign b_kind  = mode_e'(pop_data[EntryBits-1 -: 2]);
  assign b_stamp = pop_data[OpndBits +: TIME_BITS];
  assign b_opnd  = pop_data[OpndBits-1:0];

  gtt_back #(
    .TimeBits (TIME_BITS),
    .OpndBits (OpndBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_limit_i (burst_q),
    .q_valid_i     (q_valid),
    .q_kind_i      (b_kind),
    .q_stamp_i     (b_stamp),
    .q_opnd_i      (b_opnd),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
